### rtl/sorted_point_set_with_bounds_unit_macros.svh
// Assertion helpers shared by the point set RTL.
// Each macro takes a label, the condition(s) and a message string.
// Clock is i_clk, checks are off while i_rst_n is low.
`ifndef SORTED_POINT_SET_WITH_BOUNDS_UNIT_MACROS_SVH
`define SORTED_POINT_SET_WITH_BOUNDS_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SPSB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPSB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SPSB_ASSERT_IMP(lbl, ante, cons, msg)
`define SPSB_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/spsb_pkg.sv
package spsb_pkg;

    localparam int COORD_WIDTH  = 8;
    localparam int RADIUS_WIDTH = 8;
    localparam int TOTAL_WIDTH  = 7;

    localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = 8'd8;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_QUERY  = 2'd0;
    localparam t_cmd CMD_INSERT = 2'd1;
    localparam t_cmd CMD_REMOVE = 2'd2;
    localparam t_cmd CMD_CLEAR  = 2'd3;

    typedef struct packed {
        t_cmd                          cmd;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } t_in_word;

    typedef struct packed {
        logic                          found;
        logic [TOTAL_WIDTH-1:0]        point_total;
        logic signed [COORD_WIDTH-1:0] min_col;
        logic signed [COORD_WIDTH-1:0] min_row;
        logic signed [COORD_WIDTH-1:0] max_col;
        logic signed [COORD_WIDTH-1:0] max_row;
        logic                          is_empty;
        logic                          lacks_origin;
        logic                          exceeds_radius;
        logic                          valid_res;
        logic                          dropped;
    } t_out_word;

    // one table entry, row is the major sort key
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] row;
        logic signed [COORD_WIDTH-1:0] col;
    } t_point;

    // raw per-item result from the sequencer, before validation
    typedef struct packed {
        logic                          found;
        logic [TOTAL_WIDTH-1:0]        point_total;
        logic signed [COORD_WIDTH-1:0] min_col;
        logic signed [COORD_WIDTH-1:0] min_row;
        logic signed [COORD_WIDTH-1:0] max_col;
        logic signed [COORD_WIDTH-1:0] max_row;
        logic                          is_empty;
        logic                          lacks_origin;
        logic                          dropped;
    } t_stats;

    function automatic logic point_lt(input t_point a, input t_point b);
        return (a.row < b.row) || ((a.row == b.row) && (a.col < b.col));
    endfunction

endpackage

### rtl/spsb_mem.sv
module spsb_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  spsb_pkg::t_point i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output spsb_pkg::t_point o_rdata
);
    import spsb_pkg::*;

    t_point r_mem [DEPTH];
    t_point r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/spsb_ctrl.sv
`include "sorted_point_set_with_bounds_unit_macros.svh"

module spsb_ctrl #(
    parameter int MAX_POINTS = 64,
    parameter int AW         = 6,
    parameter int CW         = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  spsb_pkg::t_in_word i_in_word,
    output logic             o_busy,
    output logic             o_res_valid,
    input  logic             i_res_take,
    output spsb_pkg::t_stats o_stats,
    output logic             o_mem_we,
    output logic [AW-1:0]    o_mem_waddr,
    output spsb_pkg::t_point o_mem_wdata,
    output logic             o_mem_re,
    output logic [AW-1:0]    o_mem_raddr,
    input  spsb_pkg::t_point i_mem_rdata
);
    import spsb_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHUP   = 3'd3;
    localparam logic [2:0] S_SHDN   = 3'd4;
    localparam logic [2:0] S_STAT   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    localparam logic [CW-1:0] FULL = CW'(MAX_POINTS);

    logic [2:0]    r_state;
    logic [CW-1:0] r_count;
    t_cmd          r_cmd;
    t_point        r_key;
    logic [AW-1:0] r_addr;
    logic          r_issue;
    logic          r_pend;
    logic [AW-1:0] r_rd_addr;
    logic          r_found;
    logic [AW-1:0] r_pos;
    logic [CW-1:0] r_at;
    logic          r_dropped;
    logic          r_first;
    logic          r_origin;
    logic signed [COORD_WIDTH-1:0] r_min_col, r_min_row, r_max_col, r_max_row;

    logic accept;
    logic issue;
    logic last;
    logic walk_done;
    logic [AW-1:0] step_addr;
    logic ins_shift;
    logic rem_shift;

    assign accept = (r_state == S_IDLE) && i_in_valid;
    assign o_busy = (r_state != S_IDLE);

    // insert that must open a slot, remove that must close one
    assign ins_shift = (r_cmd == CMD_INSERT) && !r_found && (r_count != FULL)
                       && (r_at != r_count);
    assign rem_shift = (r_cmd == CMD_REMOVE) && r_found
                       && ((CW'(r_pos) + 1'b1) != r_count);

    // read issue: forward walks stop at count-1, the upward shift walks down to at
    always_comb begin
        issue     = 1'b0;
        last      = 1'b0;
        step_addr = r_addr + 1'b1;
        unique case (r_state) inside
            S_SCAN, S_STAT: begin
                issue = r_issue && (r_count != '0);
                last  = (CW'(r_addr) + 1'b1) == r_count;
            end
            S_SHDN: begin
                issue = r_issue;
                last  = (CW'(r_addr) + 1'b1) == r_count;
            end
            S_SHUP: begin
                issue     = r_issue;
                last      = CW'(r_addr) == r_at;
                step_addr = r_addr - 1'b1;
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    assign walk_done   = !issue && !r_pend;
    assign o_mem_re    = issue;
    assign o_mem_raddr = r_addr;

    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_at[AW-1:0];
        o_mem_wdata = r_key;
        unique case (r_state)
            S_DECIDE: begin
                o_mem_we = (r_cmd == CMD_INSERT) && !r_found && (r_count != FULL)
                           && (r_at == r_count);
            end
            S_SHUP: begin
                if (r_pend) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_rd_addr + 1'b1;
                    o_mem_wdata = i_mem_rdata;
                end else begin
                    o_mem_we = !r_issue;   // hole is open, drop the new point in
                end
            end
            S_SHDN: begin
                o_mem_we    = r_pend;
                o_mem_waddr = r_rd_addr - 1'b1;
                o_mem_wdata = i_mem_rdata;
            end
            default: begin
                o_mem_we = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (walk_done) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    unique case (r_cmd)
                        CMD_INSERT: begin
                            if (ins_shift) begin
                                r_state <= S_SHUP;
                            end else begin
                                r_state <= S_STAT;
                                if (!r_found && (r_count != FULL)) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                        end
                        CMD_REMOVE: begin
                            if (rem_shift) begin
                                r_state <= S_SHDN;
                            end else begin
                                r_state <= S_STAT;
                                if (r_found) begin
                                    r_count <= r_count - 1'b1;
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            r_count <= '0;
                            r_state <= S_STAT;
                        end
                        CMD_QUERY: begin
                            r_state <= S_STAT;
                        end
                        default: begin
                            r_state <= S_STAT;
                        end
                    endcase
                end
                S_SHUP: begin
                    if (walk_done) begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_STAT;
                    end
                end
                S_SHDN: begin
                    if (walk_done) begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_STAT;
                    end
                end
                S_STAT: begin
                    if (walk_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // walk and datapath registers; pend drops on every cycle without a read
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_addr <= r_addr;
            r_pend    <= 1'b1;
            if (last) begin
                r_issue <= 1'b0;
            end else begin
                r_addr <= step_addr;
            end
        end else begin
            r_pend <= 1'b0;
        end

        unique case (r_state) inside
            S_IDLE: begin
                if (accept) begin
                    r_cmd     <= i_in_word.cmd;
                    r_key.row <= i_in_word.y;
                    r_key.col <= i_in_word.x;
                    r_found   <= 1'b0;
                    r_pos     <= '0;
                    r_at      <= '0;
                    r_dropped <= 1'b0;
                    r_addr    <= '0;
                    r_issue   <= 1'b1;
                end
            end
            S_SCAN: begin
                if (r_pend) begin
                    if (i_mem_rdata == r_key) begin
                        r_found <= 1'b1;
                        r_pos   <= r_rd_addr;
                    end
                    if (point_lt(i_mem_rdata, r_key)) begin
                        r_at <= r_at + 1'b1;
                    end
                end
            end
            S_DECIDE: begin
                r_issue  <= 1'b1;
                r_first  <= 1'b1;
                r_origin <= 1'b0;
                if ((r_cmd == CMD_INSERT) && !r_found && (r_count == FULL)) begin
                    r_dropped <= 1'b1;
                end
                // insert shift from count-1 down, remove from pos+1 up, others 0
                if (ins_shift) begin
                    r_addr <= AW'(r_count - 1'b1);
                end else if (rem_shift) begin
                    r_addr <= r_pos + 1'b1;
                end else begin
                    r_addr <= '0;
                end
            end
            S_SHUP, S_SHDN: begin
                if (walk_done) begin
                    r_addr  <= '0;
                    r_issue <= 1'b1;
                end
            end
            S_STAT: begin
                if (r_pend) begin
                    r_first <= 1'b0;
                    if (i_mem_rdata == '0) begin
                        r_origin <= 1'b1;
                    end
                    if (r_first || (i_mem_rdata.col < r_min_col)) begin
                        r_min_col <= i_mem_rdata.col;
                    end
                    if (r_first || (i_mem_rdata.col > r_max_col)) begin
                        r_max_col <= i_mem_rdata.col;
                    end
                    if (r_first || (i_mem_rdata.row < r_min_row)) begin
                        r_min_row <= i_mem_rdata.row;
                    end
                    if (r_first || (i_mem_rdata.row > r_max_row)) begin
                        r_max_row <= i_mem_rdata.row;
                    end
                end
            end
            default: begin
                r_first <= r_first;
            end
        endcase
    end

    logic empty;
    assign empty = (r_count == '0);

    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_stats.found        = r_found;
        o_stats.point_total  = TOTAL_WIDTH'(r_count);
        o_stats.min_col      = empty ? '0 : r_min_col;
        o_stats.min_row      = empty ? '0 : r_min_row;
        o_stats.max_col      = empty ? '0 : r_max_col;
        o_stats.max_row      = empty ? '0 : r_max_row;
        o_stats.is_empty     = empty;
        o_stats.lacks_origin = empty || !r_origin;
        o_stats.dropped      = r_dropped;
    end

    `SPSB_ASSERT_IMP(a_count_bound, 1'b1, r_count <= FULL, "point count above table size")
    `SPSB_ASSERT_NXT(a_accept_scan, accept, r_state == S_SCAN, "accepted word did not start scan")
    `SPSB_ASSERT_IMP(a_count_step, !$stable(r_count),
        (r_count == $past(r_count) + 1'b1) || (r_count == $past(r_count) - 1'b1) ||
        (r_count == '0), "point count jumped")

endmodule

### rtl/sorted_point_set_with_bounds_unit.sv
// Sorted point set with bounding box and validation. Holds up to MAX_POINTS
// distinct signed (col,row) points in one single-port-read, single-port-write
// RAM, kept sorted by row then column. Each input word queries, inserts,
// removes a point or clears the set, and yields exactly one output word with
// the pre-operation hit flag, the new count, the bounding box (zeros when
// empty) and the empty / no-origin / over-radius / valid / dropped flags.
// One word is processed at a time; the input stalls from acceptance until
// the result moves into the output register. The cost is set by the RAM's
// one read and one write port: a lookup walk over the table, a shift walk
// to open or close a slot, and a statistics walk over the new contents. A
// finished word sits in the output register, so the next input word is
// taken while it waits. No clearing pass is needed after reset; only
// entries below the count are ever read. max_radius may be written at any
// idle time, reset value 8.
module sorted_point_set_with_bounds_unit #(
    parameter int MAX_POINTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  spsb_pkg::t_in_word   i_in_word,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output spsb_pkg::t_out_word  o_out_word,
    // max_radius register
    input  logic                 i_cfg_we,
    input  logic [spsb_pkg::RADIUS_WIDTH-1:0] i_cfg_wdata
);
    import spsb_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [RADIUS_WIDTH-1:0] r_max_radius;

    // RAM hookup
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_point        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    t_point        mem_rdata;

    logic   res_valid;
    logic   res_take;
    t_stats stats;

    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word n_out_word;

    spsb_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    spsb_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_busy      (o_in_stall),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_stats     (stats),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // |v| of a signed coordinate; one extra bit so the most negative value fits
    function automatic logic [COORD_WIDTH:0] mag(input logic signed [COORD_WIDTH-1:0] v);
        logic [COORD_WIDTH:0] ext;
        ext = {v[COORD_WIDTH-1], v};
        return v[COORD_WIDTH-1] ? (~ext + 1'b1) : ext;
    endfunction

    logic [COORD_WIDTH:0] radius_ext;
    logic                 over;

    // radius register is 8 bits against 9-bit magnitudes
    assign radius_ext = (COORD_WIDTH + 1)'(r_max_radius);
    assign over = (mag(stats.min_col) > radius_ext) || (mag(stats.max_col) > radius_ext) ||
                  (mag(stats.min_row) > radius_ext) || (mag(stats.max_row) > radius_ext);

    always_comb begin
        n_out_word.found          = stats.found;
        n_out_word.point_total    = stats.point_total;
        n_out_word.min_col        = stats.min_col;
        n_out_word.min_row        = stats.min_row;
        n_out_word.max_col        = stats.max_col;
        n_out_word.max_row        = stats.max_row;
        n_out_word.is_empty       = stats.is_empty;
        n_out_word.lacks_origin   = stats.lacks_origin;
        n_out_word.exceeds_radius = !stats.is_empty && over;
        n_out_word.valid_res      = !stats.is_empty && !stats.lacks_origin &&
                                    !(!stats.is_empty && over);
        n_out_word.dropped        = stats.dropped;
    end

    // output register loads a ready result whenever it is empty or being drained this cycle
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_max_radius <= RADIUS_RESET;
        end else begin
            if (i_cfg_we) begin
                r_max_radius <= i_cfg_wdata;
            end
            if (res_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
